>>> design/bas_pkg.sv
package bas_pkg;

   localparam int MAX_KEEP_DEFAULT = 32;

   localparam logic [7:0] CHAR_OPEN  = 8'h5B;   // '['
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;   // ']'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [3:0] POST_LEN  = 4'd9;
   localparam logic [2:0] LABEL_LEN = 3'd5;

   // keyword seeker phases
   localparam logic [1:0] PH_SEARCH  = 2'd0;
   localparam logic [1:0] PH_SKIP    = 2'd1;
   localparam logic [1:0] PH_COLLECT = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   function automatic logic [7:0] post_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h70;  // p
         4'd1:    ch = 8'h6F;  // o
         4'd2:    ch = 8'h73;  // s
         4'd3:    ch = 8'h74;  // t
         4'd4:    ch = 8'h65;  // e
         4'd5:    ch = 8'h72;  // r
         4'd6:    ch = 8'h69;  // i
         4'd7:    ch = 8'h6F;  // o
         4'd8:    ch = 8'h72;  // r
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] label_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h6C;  // l
         3'd1:    ch = 8'h61;  // a
         3'd2:    ch = 8'h62;  // b
         3'd3:    ch = 8'h65;  // e
         3'd4:    ch = 8'h6C;  // l
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic is_support(input logic [7:0] ch);
      return ((ch >= CHAR_ZERO) && (ch <= CHAR_NINE)) || (ch == CHAR_DOT);
   endfunction

endpackage

>>> design/bas_if.sv
interface bas_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       tree_last;
   modport source (output valid, output char_in, output tree_last, input ready);
   modport sink   (input valid, input char_in, input tree_last, output ready);
endinterface

interface bas_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       run_last;
   logic       tree_end;
   modport source (output valid, output char_out, output run_last, output tree_end,
                   input ready);
   modport sink   (input valid, input char_out, input run_last, input tree_end,
                   output ready);
endinterface

interface bas_csr_if;
   logic valid;
   logic ready;
   logic strip_all;
   modport source (output valid, output strip_all, input ready);
   modport sink   (input valid, input strip_all, output ready);
endinterface

>>> design/bas_ram.sv
module bas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bracket_annotation_stripper.sv
// Bracket annotation stripper: takes one tree string a byte per item on req_if
// (tree_last on the final byte) and returns the cleaned bytes on rsp_if. Bytes
// outside [...] pass through; brackets do not nest, the first ']' closes. With
// strip_all set (csr_if, write only while idle) an annotation yields nothing;
// otherwise its ']' yields the run of digits and dots that starts one character
// after the first "posterior", else after the first "label", cut to MAX_KEEP
// bytes. The final byte always passes unchanged with tree_end set, and an
// annotation still open there is dropped. run_last marks the last result of an
// input item. Rate: one item per cycle while rsp_if keeps taking results and no
// ']' is playing out digits; such a ']' stalls the input until its last digit is
// loaded, each digit being a read of the digit memory (registered read) and then
// a load of the output register. No clearing pass after reset.
module bracket_annotation_stripper #(
   parameter int MAX_KEEP = bas_pkg::MAX_KEEP_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bas_req_if.sink   req_if,
   bas_rsp_if.source rsp_if,
   bas_csr_if.sink   csr_if
);

   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CW = $clog2(MAX_KEEP + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,   // taking items
      ST_READ = 3'b010,   // reading one kept digit
      ST_SEND = 3'b100    // loading it into the output register
   } state_type;

   // ---------------- registers ----------------
   state_type       state_ff,    state_in;
   logic            strip_ff,    strip_in;
   logic            in_ann_ff,   in_ann_in;
   logic [3:0]      pmatch_ff,   pmatch_in;
   logic [2:0]      lmatch_ff,   lmatch_in;
   logic [1:0]      pphase_ff,   pphase_in;
   logic [1:0]      lphase_ff,   lphase_in;
   logic [CW-1:0]   pcount_ff,   pcount_in;
   logic [CW-1:0]   lcount_ff,   lcount_in;
   logic [CW-1:0]   idx_ff,      idx_in;      // digit being played out
   logic [CW-1:0]   n_ff,        n_in;        // digits to play out
   logic            sel_ff,      sel_in;      // 1: label memory
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      char_out_ff, char_out_in;
   logic            run_last_ff, run_last_in;
   logic            tree_end_ff, tree_end_in;

   // ---------------- memory ports ----------------
   logic            p_we, l_we;
   logic [7:0]      p_rd, l_rd;
   logic            rd_en;

   logic            out_free;
   logic            accept;
   logic            feed;        // byte inside an annotation, not ']'
   logic [7:0]      ch;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_if.valid && req_if.ready;
   assign ch = req_if.char_in;
   assign feed = accept && !req_if.tree_last && in_ann_ff && (ch != bas_pkg::CHAR_CLOSE);

   assign csr_if.ready = 1'b1;
   assign rd_en = (state_ff == ST_READ);

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.char_out = char_out_ff;
   assign rsp_if.run_last = run_last_ff;
   assign rsp_if.tree_end = tree_end_ff;

   // ---------------- keyword seekers ----------------
   always_comb begin
      pmatch_in = pmatch_ff;
      pphase_in = pphase_ff;
      pcount_in = pcount_ff;
      p_we      = 1'b0;
      lmatch_in = lmatch_ff;
      lphase_in = lphase_ff;
      lcount_in = lcount_ff;
      l_we      = 1'b0;

      if (feed) begin
         case (pphase_ff)
            bas_pkg::PH_SEARCH: begin
               if ((pmatch_ff < bas_pkg::POST_LEN) && (ch == bas_pkg::post_char(pmatch_ff))) begin
                  pmatch_in = pmatch_ff + 4'd1;
               end else begin
                  pmatch_in = (ch == bas_pkg::post_char(4'd0)) ? 4'd1 : 4'd0;
               end
               if (pmatch_in == bas_pkg::POST_LEN) begin
                  pphase_in = bas_pkg::PH_SKIP;
               end
            end
            bas_pkg::PH_SKIP: pphase_in = bas_pkg::PH_COLLECT;
            bas_pkg::PH_COLLECT: begin
               if (bas_pkg::is_support(ch)) begin
                  if (pcount_ff < CW'(MAX_KEEP)) begin
                     p_we      = 1'b1;
                     pcount_in = pcount_ff + CW'(1);
                  end
               end else begin
                  pphase_in = bas_pkg::PH_DONE;
               end
            end
            default: ;
         endcase

         case (lphase_ff)
            bas_pkg::PH_SEARCH: begin
               if ((lmatch_ff < bas_pkg::LABEL_LEN) &&
                   (ch == bas_pkg::label_char(lmatch_ff))) begin
                  lmatch_in = lmatch_ff + 3'd1;
               end else begin
                  lmatch_in = (ch == bas_pkg::label_char(3'd0)) ? 3'd1 : 3'd0;
               end
               if (lmatch_in == bas_pkg::LABEL_LEN) begin
                  lphase_in = bas_pkg::PH_SKIP;
               end
            end
            bas_pkg::PH_SKIP: lphase_in = bas_pkg::PH_COLLECT;
            bas_pkg::PH_COLLECT: begin
               if (bas_pkg::is_support(ch)) begin
                  if (lcount_ff < CW'(MAX_KEEP)) begin
                     l_we      = 1'b1;
                     lcount_in = lcount_ff + CW'(1);
                  end
               end else begin
                  lphase_in = bas_pkg::PH_DONE;
               end
            end
            default: ;
         endcase
      end

      // opening bracket or final byte: fresh seekers
      if (accept && (req_if.tree_last || (!in_ann_ff && (ch == bas_pkg::CHAR_OPEN)))) begin
         pmatch_in = '0;
         pphase_in = bas_pkg::PH_SEARCH;
         pcount_in = '0;
         lmatch_in = '0;
         lphase_in = bas_pkg::PH_SEARCH;
         lcount_in = '0;
      end
   end

   // ---------------- control and output register ----------------
   always_comb begin
      state_in     = state_ff;
      strip_in     = strip_ff;
      in_ann_in    = in_ann_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      char_out_in  = char_out_ff;
      run_last_in  = run_last_ff;
      tree_end_in  = tree_end_ff;

      if (csr_if.valid) begin
         strip_in = csr_if.strip_all;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.tree_last) begin
                  // final byte passes whatever it is; open annotation dropped
                  rsp_valid_in = 1'b1;
                  char_out_in  = ch;
                  run_last_in  = 1'b1;
                  tree_end_in  = 1'b1;
                  in_ann_in    = 1'b0;
               end else if (!in_ann_ff) begin
                  if (ch == bas_pkg::CHAR_OPEN) begin
                     in_ann_in = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b1;
                     char_out_in  = ch;
                     run_last_in  = 1'b1;
                     tree_end_in  = 1'b0;
                  end
               end else if (ch == bas_pkg::CHAR_CLOSE) begin
                  in_ann_in = 1'b0;
                  idx_in    = '0;
                  // posterior wins once found, even with an empty run
                  if (!strip_ff && (pphase_ff != bas_pkg::PH_SEARCH)) begin
                     sel_in = 1'b0;
                     n_in   = pcount_ff;
                     if (pcount_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end else if (!strip_ff && (lphase_ff != bas_pkg::PH_SEARCH)) begin
                     sel_in = 1'b1;
                     n_in   = lcount_ff;
                     if (lcount_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_out_in  = sel_ff ? l_rd : p_rd;
               run_last_in  = ((idx_ff + CW'(1)) == n_ff);
               tree_end_in  = 1'b0;
               idx_in       = idx_ff + CW'(1);
               state_in     = run_last_in ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         strip_ff     <= 1'b0;
         in_ann_ff    <= 1'b0;
         pmatch_ff    <= '0;
         lmatch_ff    <= '0;
         pphase_ff    <= bas_pkg::PH_SEARCH;
         lphase_ff    <= bas_pkg::PH_SEARCH;
         pcount_ff    <= '0;
         lcount_ff    <= '0;
         idx_ff       <= '0;
         n_ff         <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         strip_ff     <= strip_in;
         in_ann_ff    <= in_ann_in;
         pmatch_ff    <= pmatch_in;
         lmatch_ff    <= lmatch_in;
         pphase_ff    <= pphase_in;
         lphase_ff    <= lphase_in;
         pcount_ff    <= pcount_in;
         lcount_ff    <= lcount_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_out_ff <= char_out_in;
      run_last_ff <= run_last_in;
      tree_end_ff <= tree_end_in;
   end

   // ---------------- digit stores ----------------
   bas_ram #(
      .WIDTH (8),
      .DEPTH (MAX_KEEP)
   ) u_post_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (pcount_ff[AW-1:0]),
      .wr_data (ch),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (p_rd)
   );

   bas_ram #(
      .WIDTH (8),
      .DEPTH (MAX_KEEP)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (lcount_ff[AW-1:0]),
      .wr_data (ch),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (l_rd)
   );

endmodule

>>> sim/bas_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the stripper, works out the cleaned bytes
// each accepted input item should cause and checks every result in order.
module bas_checker #(
   parameter int MAX_KEEP = bas_pkg::MAX_KEEP_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_char,
   input  logic       rsp_run_last,
   input  logic       rsp_tree_end,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_strip_all,
   output int         fail_count,
   output int         outstanding
);

   typedef enum int {TRK_POST = 0, TRK_LABEL = 1} tracker_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       run_last;
      logic       tree_end;
   } kept_type;

   kept_type   kept_q[$];
   logic       strip_copy;
   logic       in_ann;
   // keyword trackers, one per keyword
   logic [3:0] hits   [2];
   logic [1:0] phase  [2];
   logic [6:0] count  [2];
   logic [7:0] digits [2][MAX_KEEP];

   task automatic clear_trackers();
      for (int t = 0; t < 2; t++) begin
         hits[t]  = '0;
         phase[t] = bas_pkg::PH_SEARCH;
         count[t] = '0;
      end
   endtask

   task automatic keep_item(input kept_type e);
      kept_q.insert(kept_q.size(), e);
   endtask

   task automatic feed_tracker(input tracker_type t, input logic [7:0] c);
      string kw;
      kw = (t == TRK_POST) ? "posterior" : "label";
      case (phase[t])
         bas_pkg::PH_SEARCH: begin
            if (hits[t] < kw.len() && c == kw[hits[t]])
               hits[t] = hits[t] + 4'd1;
            else
               hits[t] = (c == kw[0]) ? 4'd1 : 4'd0;
            if (hits[t] >= kw.len())
               phase[t] = bas_pkg::PH_SKIP;
         end
         bas_pkg::PH_SKIP: phase[t] = bas_pkg::PH_COLLECT;
         bas_pkg::PH_COLLECT: begin
            if ((c >= bas_pkg::CHAR_ZERO && c <= bas_pkg::CHAR_NINE) ||
                c == bas_pkg::CHAR_DOT) begin
               if (count[t] < MAX_KEEP) begin
                  digits[t][count[t]] = c;
                  count[t] = count[t] + 7'd1;
               end
            end else begin
               phase[t] = bas_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
   endtask

   // one input byte -> zero or more kept bytes onto kept_q
   task automatic clean_byte(input logic [7:0] c, input logic last);
      kept_type    e;
      tracker_type src;
      int          n;
      if (last) begin
         e = '{char_out: c, run_last: 1'b1, tree_end: 1'b1};
         keep_item(e);
         in_ann = 1'b0;
         clear_trackers();
      end else if (!in_ann) begin
         if (c == bas_pkg::CHAR_OPEN) begin
            in_ann = 1'b1;
            clear_trackers();
         end else begin
            e = '{char_out: c, run_last: 1'b1, tree_end: 1'b0};
            keep_item(e);
         end
      end else if (c != bas_pkg::CHAR_CLOSE) begin
         feed_tracker(TRK_POST, c);
         feed_tracker(TRK_LABEL, c);
      end else begin
         in_ann = 1'b0;
         n = 0;
         src = TRK_POST;
         if (!strip_copy) begin
            if (phase[TRK_POST] != bas_pkg::PH_SEARCH) begin
               src = TRK_POST;
               n = count[TRK_POST];
            end else if (phase[TRK_LABEL] != bas_pkg::PH_SEARCH) begin
               src = TRK_LABEL;
               n = count[TRK_LABEL];
            end
         end
         if (n > MAX_KEEP)
            n = MAX_KEEP;
         for (int k = 0; k < n; k++) begin
            e = '{char_out: digits[src][k], run_last: (k == n - 1), tree_end: 1'b0};
            keep_item(e);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      kept_type want;
      if (reset) begin
         strip_copy = 1'b0;
         in_ann     = 1'b0;
         clear_trackers();
         kept_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (kept_q.size() == 0) begin
               $display("%0t: unexpected item: expected none,", $time,
                        " got char %h run_last %b tree_end %b",
                        rsp_char, rsp_run_last, rsp_tree_end);
               fail_count++;
            end else begin
               want = kept_q.pop_front();
               if (rsp_char !== want.char_out || rsp_run_last !== want.run_last ||
                   rsp_tree_end !== want.tree_end) begin
                  $display("%0t: mismatch: expected char %h run_last %b tree_end %b,",
                           $time, want.char_out, want.run_last, want.tree_end,
                           " got char %h run_last %b tree_end %b",
                           rsp_char, rsp_run_last, rsp_tree_end);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            clean_byte(req_char, req_last);
         if (csr_valid && csr_ready)
            strip_copy = csr_strip_all;
      end
      outstanding = kept_q.size();
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_KEEP    = bas_pkg::MAX_KEEP_DEFAULT;
   // longest internal busy spell: a ']' that plays out a full run of digits
   localparam int SETTLE      = 2 * MAX_KEEP + 8;
   localparam int HOLD_CYCLES = 150;
   localparam int IDLE_PCT    = 27;

   logic clock;
   logic reset;

   bas_req_if req_if ();
   bas_rsp_if rsp_if ();
   bas_csr_if csr_if ();

   int   fail_count;
   int   outstanding;
   logic no_idle;        // sender and receiver both run flat out
   logic hold_request;   // asks the receiver for one long hold-off

   logic [7:0] tree_q[$];   // bytes of the tree being built

   bracket_annotation_stripper #(.MAX_KEEP(MAX_KEEP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   bas_checker #(.MAX_KEEP(MAX_KEEP)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_char      (req_if.char_in),
      .req_last      (req_if.tree_last),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_char      (rsp_if.char_out),
      .rsp_run_last  (rsp_if.run_last),
      .rsp_tree_end  (rsp_if.tree_end),
      .csr_valid     (csr_if.valid),
      .csr_ready     (csr_if.ready),
      .csr_strip_all (csr_if.strip_all),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: random back-pressure, one long hold-off on request. The hold is
   // counted here so the sender keeps pushing while the block backs up.
   initial begin : receiver
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= IDLE_PCT);
         end
      end
   end

   // --- sender side ---------------------------------------------------------

   // One item; random idle cycles ahead of it, then hold until taken.
   task automatic send_byte(input logic [7:0] c, input logic last);
      while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.char_in   <= c;
      req_if.tree_last <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Sends tree_q with tree_last on its final byte, then empties it.
   task automatic send_tree();
      for (int i = 0; i < tree_q.size(); i++)
         send_byte(tree_q[i], i == tree_q.size() - 1);
      tree_q.delete();
   endtask

   // Drops valid, waits for every expected item, then lets the block go quiet
   // (a '[' or a byte inside an annotation leaves nothing to wait on).
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_strip(input logic v);
      settle();
      csr_if.valid     <= 1'b1;
      csr_if.strip_all <= v;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // --- tree building -------------------------------------------------------

   // appends one byte to the tree being built
   task automatic put_byte(input logic [7:0] b);
      tree_q.insert(tree_q.size(), b);
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endtask

   // support run: digits with the odd dot
   task automatic push_run(input int lo, input int hi);
      int n;
      n = $urandom_range(hi, lo);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(4, 0) == 0)
            put_byte(bas_pkg::CHAR_DOT);
         else
            put_byte(bas_pkg::CHAR_ZERO + 8'($urandom_range(9, 0)));
      end
   endtask

   // the one character skipped after a keyword: may be anything but ']'
   task automatic push_skip();
      logic [7:0] b;
      case ($urandom_range(3, 0))
         0:       b = "=";
         1:       b = ":";
         2:       b = bas_pkg::CHAR_ZERO + 8'($urandom_range(9, 0));
         default: b = 8'($urandom_range(255, 0));
      endcase
      if (b == bas_pkg::CHAR_CLOSE)
         b = "=";
      put_byte(b);
   endtask

   // Random tree: plain bytes and annotations, most of them well formed with a
   // keyword and a run, the rest noise, truncated keywords or left open.
   task automatic build_tree();
      int         segs;
      int         n;
      logic [7:0] b;
      segs = $urandom_range(5, 1);
      for (int s = 0; s < segs; s++) begin
         if ($urandom_range(9, 0) < 3) begin
            // plain text; '[' swapped out so the structure stays intended
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++) begin
               b = 8'($urandom_range(255, 0));
               if (b == bas_pkg::CHAR_OPEN)
                  b = ",";
               put_byte(b);
            end
         end else begin
            put_byte(bas_pkg::CHAR_OPEN);
            case ($urandom_range(9, 0))
               0, 1: begin
                  push_str("&posterior");
                  push_skip();
                  push_run(1, 6);
                  if ($urandom_range(1, 0) != 0)
                     push_str(",x1");
               end
               2: begin
                  push_str("&label");
                  push_skip();
                  push_run(1, 6);
               end
               3: begin
                  // both keywords: posterior wins even when later
                  push_str("label");
                  push_skip();
                  push_run(1, 4);
                  push_str(",posterior");
                  push_skip();
                  push_run(1, 4);
               end
               4: push_str("posterior");   // ']' straight after the keyword
               5: begin
                  // posterior with empty run, no fallback to label
                  push_str("posterior=,label=");
                  push_run(1, 3);
               end
               6: begin
                  // run from just under to past the keep limit
                  push_str("posterior");
                  push_skip();
                  push_run(MAX_KEEP - 2, MAX_KEEP + 8);
               end
               7: begin
                  // partial keyword before the real one
                  if ($urandom_range(1, 0) != 0)
                     push_str("posteriposterior");
                  else
                     push_str("llabe label");
                  push_skip();
                  push_run(1, 5);
               end
               8: begin
                  // noise, stray '[' allowed
                  n = $urandom_range(8, 0);
                  for (int i = 0; i < n; i++) begin
                     b = 8'($urandom_range(255, 0));
                     if (b == bas_pkg::CHAR_CLOSE)
                        b = bas_pkg::CHAR_OPEN;
                     put_byte(b);
                  end
               end
               default: begin
                  push_str("label");
                  push_skip();
               end
            endcase
            // last annotation sometimes left open for the final byte
            if (!(s == segs - 1 && $urandom_range(7, 0) == 0))
               put_byte(bas_pkg::CHAR_CLOSE);
         end
      end
      case ($urandom_range(5, 0))
         0:       put_byte(bas_pkg::CHAR_OPEN);
         1:       put_byte(bas_pkg::CHAR_CLOSE);
         default: put_byte(8'($urandom_range(255, 0)));
      endcase
   endtask

   task automatic run_random(input int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         build_tree();
         sent += tree_q.size();
         send_tree();
      end
   endtask

   // --- main sequence -------------------------------------------------------

   initial begin
      reset            = 1'b1;
      no_idle          = 1'b0;
      hold_request     = 1'b0;
      req_if.valid     = 1'b0;
      req_if.char_in   = '0;
      req_if.tree_last = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.strip_all = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, keep mode
      write_strip(1'b0);
      // byte extremes around a label value
      put_byte(8'h00);
      push_str("[label=7]");
      put_byte(8'hFF);
      send_tree();
      // keyword right before ']', final byte '[' outside
      push_str("[label]");
      put_byte(bas_pkg::CHAR_OPEN);
      send_tree();
      // final ']' inside an open annotation
      push_str("[ab");
      put_byte(bas_pkg::CHAR_CLOSE);
      send_tree();
      // annotation with no keyword
      push_str("[q]x");
      send_tree();

      write_strip(1'b1);
      run_random(10);

      // flat out with one long receiver hold: the block fills and stalls
      write_strip(1'b0);
      @(negedge clock);
      no_idle      <= 1'b1;
      hold_request <= 1'b1;
      run_random(35);
      @(negedge clock);
      no_idle <= 1'b0;
      run_random(15);

      write_strip(1'b1);
      run_random(10);
      write_strip(1'b0);
      run_random(10);

      settle();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
